[sv/assert_macros.svh]
// Assertion macros shared by the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

[sv/dqsi_pkg.sv]
// Types, constants and the control store of the sorted-insert deque.
package dqsi_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;
  localparam int FUNC_W  = 3;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_BACK  = 3'd0,
    FUNC_PUSH_FRONT = 3'd1,
    FUNC_INSERT     = 3'd2,
    FUNC_POP_FRONT  = 3'd3,
    FUNC_POP_BACK   = 3'd4,
    FUNC_READ_FWD   = 3'd5,
    FUNC_READ_BWD   = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] out_value;
    logic               out_valid;
    logic               last;
    logic [1:0]         status;
    logic [CNT_W-1:0]   count;
  } rsp_t;

  // datapath control fields
  typedef enum logic [2:0] {
    ADDR_BACK      = 3'd0,
    ADDR_FRONT_DEC = 3'd1,
    ADDR_FRONT     = 3'd2,
    ADDR_LAST      = 3'd3,
    ADDR_SCAN      = 3'd4
  } addr_e;

  typedef enum logic [2:0] {
    EMIT_NONE  = 3'd0,
    EMIT_OK    = 3'd1,
    EMIT_FULL  = 3'd2,
    EMIT_EMPTY = 3'd3,
    EMIT_DATA  = 3'd4
  } emit_e;

  typedef enum logic [1:0] {
    CNT_KEEP = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_e;

  typedef enum logic [1:0] {
    FR_KEEP = 2'd0,
    FR_INC  = 2'd1,
    FR_DEC  = 2'd2
  } front_op_e;

  typedef enum logic [1:0] {
    IDX_KEEP = 2'd0,
    IDX_CLR  = 2'd1,
    IDX_INC  = 2'd2
  } idx_op_e;

  typedef enum logic [1:0] {
    FND_KEEP = 2'd0,
    FND_CLR  = 2'd1,
    FND_SET  = 2'd2
  } fnd_op_e;

  typedef enum logic [2:0] {
    COND_NEVER   = 3'd0,
    COND_ALWAYS  = 3'd1,
    COND_FULL    = 3'd2,
    COND_EMPTY   = 3'd3,
    COND_END     = 3'd4,
    COND_NOT_END = 3'd5,
    COND_SCAN    = 3'd6
  } cond_e;

  typedef struct packed {
    logic      mem_we;
    addr_e     addr;
    emit_e     emit;
    logic      last_idx;   // last flag from scan index instead of constant one
    cnt_op_e   cnt_op;
    front_op_e front_op;
    idx_op_e   idx_op;
    logic      carry_ld;   // value register takes the word just read
    fnd_op_e   fnd_op;
  } dp_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_end;
    logic scan_gt;
  } dp_stat_t;

  localparam int NUM_STEPS = 21;
  localparam int PC_W      = $clog2(NUM_STEPS);

  typedef struct packed {
    dp_ctrl_t          dp;
    cond_e             cond;
    logic [PC_W-1:0]   target;
    logic              done;
  } ucode_t;

  localparam logic [PC_W-1:0] STEP_PB_CHK   = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_PB       = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_PF_CHK   = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_PF       = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_SI_CHK   = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_SI_RD    = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_SI_CMP   = PC_W'(6);
  localparam logic [PC_W-1:0] STEP_SI_PUT   = PC_W'(7);
  localparam logic [PC_W-1:0] STEP_SI_SKIP  = PC_W'(8);
  localparam logic [PC_W-1:0] STEP_SI_TAIL  = PC_W'(9);
  localparam logic [PC_W-1:0] STEP_POF_CHK  = PC_W'(10);
  localparam logic [PC_W-1:0] STEP_POF_RD   = PC_W'(11);
  localparam logic [PC_W-1:0] STEP_POF_EM   = PC_W'(12);
  localparam logic [PC_W-1:0] STEP_POB_CHK  = PC_W'(13);
  localparam logic [PC_W-1:0] STEP_POB_RD   = PC_W'(14);
  localparam logic [PC_W-1:0] STEP_POB_EM   = PC_W'(15);
  localparam logic [PC_W-1:0] STEP_RD_CHK   = PC_W'(16);
  localparam logic [PC_W-1:0] STEP_RD_FIRST = PC_W'(17);
  localparam logic [PC_W-1:0] STEP_RD_LOOP  = PC_W'(18);
  localparam logic [PC_W-1:0] STEP_FULL     = PC_W'(19);
  localparam logic [PC_W-1:0] STEP_EMPTY    = PC_W'(20);

  localparam dp_ctrl_t DP_NOP = '{
    mem_we:   1'b0,
    addr:     ADDR_SCAN,
    emit:     EMIT_NONE,
    last_idx: 1'b0,
    cnt_op:   CNT_KEEP,
    front_op: FR_KEEP,
    idx_op:   IDX_KEEP,
    carry_ld: 1'b0,
    fnd_op:   FND_KEEP
  };

  localparam ucode_t UCODE_NOP = '{
    dp:     DP_NOP,
    cond:   COND_NEVER,
    target: '0,
    done:   1'b0
  };

  // control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t u;
    u = UCODE_NOP;
    case (pc)
      STEP_PB_CHK: begin
        u.cond   = COND_FULL;
        u.target = STEP_FULL;
      end
      STEP_PB: begin
        u.dp.mem_we = 1'b1;
        u.dp.addr   = ADDR_BACK;
        u.dp.cnt_op = CNT_INC;
        u.dp.emit   = EMIT_OK;
        u.done      = 1'b1;
      end
      STEP_PF_CHK: begin
        u.cond   = COND_FULL;
        u.target = STEP_FULL;
      end
      STEP_PF: begin
        u.dp.mem_we   = 1'b1;
        u.dp.addr     = ADDR_FRONT_DEC;
        u.dp.front_op = FR_DEC;
        u.dp.cnt_op   = CNT_INC;
        u.dp.emit     = EMIT_OK;
        u.done        = 1'b1;
      end
      STEP_SI_CHK: begin
        u.dp.idx_op = IDX_CLR;
        u.dp.fnd_op = FND_CLR;
        u.cond      = COND_FULL;
        u.target    = STEP_FULL;
      end
      STEP_SI_RD: begin
        u.dp.addr = ADDR_SCAN;
        u.cond    = COND_END;
        u.target  = STEP_SI_TAIL;
      end
      STEP_SI_CMP: begin
        u.cond   = COND_SCAN;
        u.target = STEP_SI_SKIP;
      end
      // drop the carried word here and pick up the one it displaces
      STEP_SI_PUT: begin
        u.dp.mem_we   = 1'b1;
        u.dp.addr     = ADDR_SCAN;
        u.dp.carry_ld = 1'b1;
        u.dp.fnd_op   = FND_SET;
        u.dp.idx_op   = IDX_INC;
        u.cond        = COND_ALWAYS;
        u.target      = STEP_SI_RD;
      end
      STEP_SI_SKIP: begin
        u.dp.idx_op = IDX_INC;
        u.cond      = COND_ALWAYS;
        u.target    = STEP_SI_RD;
      end
      STEP_SI_TAIL: begin
        u.dp.mem_we = 1'b1;
        u.dp.addr   = ADDR_SCAN;
        u.dp.cnt_op = CNT_INC;
        u.dp.emit   = EMIT_OK;
        u.done      = 1'b1;
      end
      STEP_POF_CHK: begin
        u.cond   = COND_EMPTY;
        u.target = STEP_EMPTY;
      end
      STEP_POF_RD: begin
        u.dp.addr = ADDR_FRONT;
      end
      STEP_POF_EM: begin
        u.dp.emit     = EMIT_DATA;
        u.dp.front_op = FR_INC;
        u.dp.cnt_op   = CNT_DEC;
        u.done        = 1'b1;
      end
      STEP_POB_CHK: begin
        u.cond   = COND_EMPTY;
        u.target = STEP_EMPTY;
      end
      STEP_POB_RD: begin
        u.dp.addr = ADDR_LAST;
      end
      STEP_POB_EM: begin
        u.dp.emit   = EMIT_DATA;
        u.dp.cnt_op = CNT_DEC;
        u.done      = 1'b1;
      end
      STEP_RD_CHK: begin
        u.dp.idx_op = IDX_CLR;
        u.cond      = COND_EMPTY;
        u.target    = STEP_EMPTY;
      end
      STEP_RD_FIRST: begin
        u.dp.addr   = ADDR_SCAN;
        u.dp.idx_op = IDX_INC;
      end
      // emit the word read last cycle while fetching the next one
      STEP_RD_LOOP: begin
        u.dp.addr     = ADDR_SCAN;
        u.dp.idx_op   = IDX_INC;
        u.dp.emit     = EMIT_DATA;
        u.dp.last_idx = 1'b1;
        u.cond        = COND_NOT_END;
        u.target      = STEP_RD_LOOP;
        u.done        = 1'b1;
      end
      STEP_FULL: begin
        u.dp.emit = EMIT_FULL;
        u.done    = 1'b1;
      end
      STEP_EMPTY: begin
        u.dp.emit = EMIT_EMPTY;
        u.done    = 1'b1;
      end
      default: begin
        u.done = 1'b1;
      end
    endcase
    return u;
  endfunction

endpackage

[sv/dqsi_seq.sv]
// Microcode sequencer: request dispatch, step counter and conditional jumps.
`include "assert_macros.svh"

module dqsi_seq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic [dqsi_pkg::FUNC_W-1:0] func_i,
  input  dqsi_pkg::dp_stat_t      stat_i,
  output dqsi_pkg::dp_ctrl_t      ctrl_o,
  output logic                    busy
);

  logic                       busy_q, busy_d;
  logic [dqsi_pkg::PC_W-1:0]  pc_q, pc_d;
  dqsi_pkg::ucode_t           uc;
  logic                       take;
  logic                       accept;
  logic                       known_func;
  logic [dqsi_pkg::PC_W-1:0]  entry;

  assign uc     = dqsi_pkg::ucode_rom(pc_q);
  assign accept = start && !busy_q;
  assign busy   = busy_q;
  assign ctrl_o = busy_q ? uc.dp : dqsi_pkg::DP_NOP;

  always_comb begin
    case (uc.cond)
      dqsi_pkg::COND_ALWAYS:  take = 1'b1;
      dqsi_pkg::COND_FULL:    take = stat_i.full;
      dqsi_pkg::COND_EMPTY:   take = stat_i.empty;
      dqsi_pkg::COND_END:     take = stat_i.at_end;
      dqsi_pkg::COND_NOT_END: take = !stat_i.at_end;
      dqsi_pkg::COND_SCAN:    take = stat_i.scan_gt;
      default:                take = 1'b0;
    endcase
  end

  always_comb begin
    known_func = 1'b1;
    case (func_i)
      dqsi_pkg::FUNC_PUSH_BACK:  entry = dqsi_pkg::STEP_PB_CHK;
      dqsi_pkg::FUNC_PUSH_FRONT: entry = dqsi_pkg::STEP_PF_CHK;
      dqsi_pkg::FUNC_INSERT:     entry = dqsi_pkg::STEP_SI_CHK;
      dqsi_pkg::FUNC_POP_FRONT:  entry = dqsi_pkg::STEP_POF_CHK;
      dqsi_pkg::FUNC_POP_BACK:   entry = dqsi_pkg::STEP_POB_CHK;
      dqsi_pkg::FUNC_READ_FWD,
      dqsi_pkg::FUNC_READ_BWD:   entry = dqsi_pkg::STEP_RD_CHK;
      default: begin
        entry      = dqsi_pkg::STEP_PB_CHK;
        known_func = 1'b0;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (accept && known_func) begin
        busy_d = 1'b1;
        pc_d   = entry;
      end
    end else if (take) begin
      pc_d = uc.target;
    end else if (uc.done) begin
      busy_d = 1'b0;
    end else begin
      pc_d = pc_q + dqsi_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  `ASSERT_NEXT(a_accept_runs, clk_i, rst_ni, accept && known_func, busy_q)
  `ASSERT_NEXT(a_step_holds, clk_i, rst_ni, busy_q && !take && !uc.done,
               busy_q && pc_q == $past(pc_q) + dqsi_pkg::PC_W'(1))

endmodule

[sv/dqsi_dp.sv]
// Deque datapath: entry memory, pointers, scan counter, compare and result register.
`include "assert_macros.svh"

module dqsi_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  dqsi_pkg::req_t      req_i,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  dqsi_pkg::dp_ctrl_t  ctrl_i,
  output dqsi_pkg::dp_stat_t  stat_o,
  output logic                result_strobe_o,
  output dqsi_pkg::rsp_t      rsp_o
);

  localparam int PW = dqsi_pkg::PTR_W;
  localparam int CW = dqsi_pkg::CNT_W;
  localparam int VW = dqsi_pkg::VALUE_W;

  logic [VW-1:0]  mem [dqsi_pkg::DEPTH];
  logic [VW-1:0]  rd_q;
  logic [VW-1:0]  val_q;
  logic           dir_q;
  logic           cmp_signed_q;
  logic           found_q, found_d;
  logic [PW-1:0]  front_q, front_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  scan_off;
  logic [PW-1:0]  front_dec;
  logic [PW-1:0]  addr;
  logic [VW-1:0]  sign_mask;
  logic           gt;
  logic           strobe_q;
  dqsi_pkg::rsp_t rsp_q, rsp_d;

  function automatic logic [PW-1:0] slot(input logic [PW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(dqsi_pkg::DEPTH)) begin
      sum = sum - (CW+1)'(dqsi_pkg::DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  function automatic logic [VW-1:0] val_from_rd(input logic [VW-1:0] w);
    return w;
  endfunction

  assign front_dec = (front_q == '0) ? PW'(dqsi_pkg::DEPTH - 1) : front_q - PW'(1);
  // backward reads walk the scan index from the back
  assign scan_off  = dir_q ? count_q - CW'(1) - idx_q : idx_q;

  always_comb begin
    case (ctrl_i.addr)
      dqsi_pkg::ADDR_BACK:      addr = slot(front_q, count_q);
      dqsi_pkg::ADDR_FRONT_DEC: addr = front_dec;
      dqsi_pkg::ADDR_FRONT:     addr = front_q;
      dqsi_pkg::ADDR_LAST:      addr = slot(front_q, count_q - CW'(1));
      default:                  addr = slot(front_q, scan_off);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_we) begin
      mem[addr] <= val_q;
    end
    rd_q <= mem[addr];
  end

  assign sign_mask = {cmp_signed_q, {(VW-1){1'b0}}};
  assign gt        = (val_q ^ sign_mask) > (rd_q ^ sign_mask);

  assign stat_o.full    = (count_q == CW'(dqsi_pkg::DEPTH));
  assign stat_o.empty   = (count_q == '0);
  assign stat_o.at_end  = (idx_q == count_q);
  assign stat_o.scan_gt = !found_q && gt;

  always_comb begin
    case (ctrl_i.cnt_op)
      dqsi_pkg::CNT_INC: count_d = count_q + CW'(1);
      dqsi_pkg::CNT_DEC: count_d = count_q - CW'(1);
      default:           count_d = count_q;
    endcase
    case (ctrl_i.front_op)
      dqsi_pkg::FR_INC: front_d = slot(front_q, CW'(1));
      dqsi_pkg::FR_DEC: front_d = front_dec;
      default:          front_d = front_q;
    endcase
    case (ctrl_i.idx_op)
      dqsi_pkg::IDX_CLR: idx_d = '0;
      dqsi_pkg::IDX_INC: idx_d = idx_q + CW'(1);
      default:           idx_d = idx_q;
    endcase
    case (ctrl_i.fnd_op)
      dqsi_pkg::FND_CLR: found_d = 1'b0;
      dqsi_pkg::FND_SET: found_d = 1'b1;
      default:           found_d = found_q;
    endcase
  end

  always_comb begin
    rsp_d.out_value = '0;
    rsp_d.out_valid = 1'b0;
    rsp_d.last      = 1'b1;
    rsp_d.status    = dqsi_pkg::STATUS_OK;
    rsp_d.count     = count_d;
    case (ctrl_i.emit)
      dqsi_pkg::EMIT_FULL:  rsp_d.status = dqsi_pkg::STATUS_FULL;
      dqsi_pkg::EMIT_EMPTY: rsp_d.status = dqsi_pkg::STATUS_EMPTY;
      dqsi_pkg::EMIT_DATA: begin
        rsp_d.out_value = val_from_rd(rd_q);
        rsp_d.out_valid = 1'b1;
        rsp_d.last      = ctrl_i.last_idx ? stat_o.at_end : 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      val_q <= req_i.value;
      dir_q <= (req_i.func == dqsi_pkg::FUNC_READ_BWD);
    end else if (ctrl_i.carry_ld) begin
      val_q <= rd_q;
    end
    idx_q <= idx_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q      <= '0;
      count_q      <= '0;
      found_q      <= 1'b0;
      strobe_q     <= 1'b0;
      cmp_signed_q <= 1'b0;
    end else begin
      front_q  <= front_d;
      count_q  <= count_d;
      found_q  <= found_d;
      strobe_q <= (ctrl_i.emit != dqsi_pkg::EMIT_NONE);
      if (cfg_we_i) begin
        cmp_signed_q <= cfg_wdata_i;
      end
    end
  end

  assign result_strobe_o = strobe_q;
  assign rsp_o           = rsp_q;

  `ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(dqsi_pkg::DEPTH))
  `ASSERT_NOW(a_full_count, clk_i, rst_ni,
              strobe_q && rsp_q.status == dqsi_pkg::STATUS_FULL,
              rsp_q.count == CW'(dqsi_pkg::DEPTH) && !rsp_q.out_valid)

endmodule

[sv/deque_with_sorted_insert.sv]
// Bounded deque with sorted insert. Pushes to a full deque are refused; pops and reads of an
// empty one get an empty answer. A read of N entries gives one result per cycle. A sorted
// insert runs a read-compare-write loop over the single-port entry memory. Results are
// registered, appear in the cycle after the step that makes them and are never held off.
// A new request is taken only while busy is low. Reset clears the front pointer, count,
// sequencer, strobe and compare mode; not memory, scan index or result value.
module deque_with_sorted_insert (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  dqsi_pkg::req_t  req_i,
  output logic            busy,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  output logic            result_strobe_o,
  output dqsi_pkg::rsp_t  rsp_o
);

  dqsi_pkg::dp_ctrl_t ctrl;
  dqsi_pkg::dp_stat_t stat;
  logic               accept;

  assign accept = start && !busy;

  dqsi_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (req_i.func),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  dqsi_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .req_i           (req_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .result_strobe_o (result_strobe_o),
    .rsp_o           (rsp_o)
  );

endmodule
